// ----- design/clpt_pkg.sv -----
// Shared constants for the closest-points-between-two-lines datapath.
package clpt_pkg;

  // Default coordinate width in bits (signed fixed point).
  localparam int COORD_WIDTH_DEF = 32;

  // Width and reset value of the parallel limit register.
  localparam int LIMIT_W = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1;

  // Operand chunk width of one multiplier slice.
  localparam int MUL_CW = 34;

  // Fraction bits kept in the line parameters s and t.
  localparam int SFRAC = 32;

endpackage

// ----- design/clpt_mul.sv -----
// Pipelined signed multiplier built from chunk-by-chunk partial products.
module clpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic [AW+BW-1:0]     p
);
  import clpt_pkg::*;

  localparam int NA  = (AW + MUL_CW - 1) / MUL_CW;
  localparam int NB  = (BW + MUL_CW - 1) / MUL_CW;
  localparam int NP  = NA * NB;
  localparam int AXW = NA * MUL_CW;
  localparam int BXW = NB * MUL_CW;
  localparam int ACW = AXW + BXW;
  localparam int OW  = AW + BW;

  logic [AW-1:0]  a_mag;
  logic [BW-1:0]  b_mag;
  logic [AXW-1:0] am_r  [NP];
  logic [BXW-1:0] bm_r  [NP];
  logic           neg_r [NP+1];
  logic [ACW-1:0] acc_r [1:NP];
  logic [OW-1:0]  p_r;

  // Split operands into magnitude and sign
  assign a_mag = a[AW-1] ? (AW'(~a) + AW'(1)) : AW'(a);
  assign b_mag = b[BW-1] ? (BW'(~b) + BW'(1)) : BW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      am_r[0]  <= AXW'(a_mag);
      bm_r[0]  <= BXW'(b_mag);
      neg_r[0] <= a[AW-1] ^ b[BW-1];
    end
  end

  // Accumulate one partial product per stage
  for (genvar k = 1; k <= NP; k++) begin : g_pp
    localparam int I = (k - 1) / NB;
    localparam int J = (k - 1) % NB;
    logic [2*MUL_CW-1:0] pp;

    assign pp = am_r[k-1][I*MUL_CW +: MUL_CW] * bm_r[k-1][J*MUL_CW +: MUL_CW];

    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) acc_r[k] <= ACW'(pp) << ((I + J) * MUL_CW);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) acc_r[k] <= acc_r[k-1] + (ACW'(pp) << ((I + J) * MUL_CW));
      end
    end

    if (k < NP) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          am_r[k] <= am_r[k-1];
          bm_r[k] <= bm_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) neg_r[k] <= neg_r[k-1];
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r[NP] ? (OW'(~acc_r[NP][OW-1:0]) + OW'(1)) : acc_r[NP][OW-1:0];
    end
  end

  assign p = p_r;

endmodule

// ----- design/clpt_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, clamped quotient.
module clpt_div #(
  parameter int NUMW = 133,
  parameter int DENW = 132,
  parameter int QB   = 65
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QB:0]     quo
);
  import clpt_pkg::*;

  localparam int SH   = QB - SFRAC;
  localparam int CMPW = (NUMW > DENW + SH) ? NUMW : DENW + SH;

  logic [DENW-1:0] rem_r   [QB];
  logic [DENW-1:0] den_r   [QB];
  logic [QB-1:0]   nlo_r   [QB];
  logic            clamp_r [QB+1];
  logic [QB-1:0]   quo_r   [1:QB];

  // Seed the remainder and flag quotients beyond the clamp value
  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r[0] <= CMPW'(num) >= (CMPW'(den) << SH);
      rem_r[0]   <= DENW'(num >> SH);
      nlo_r[0]   <= {num[SH-1:0], {SFRAC{1'b0}}};
      den_r[0]   <= den;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DENW:0] trial;
    logic          ge;

    assign trial = {rem_r[k-1], nlo_r[k-1][QB-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};

    if (k < QB) begin : g_rem
      logic [DENW:0] diff;
      assign diff = trial - {1'b0, den_r[k-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
          nlo_r[k] <= nlo_r[k-1] << 1;
          den_r[k] <= den_r[k-1];
        end
      end
    end

    if (k == 1) begin : g_q0
      always_ff @(posedge clk) begin
        if (en) quo_r[k] <= QB'(ge);
      end
    end else begin : g_qn
      always_ff @(posedge clk) begin
        if (en) quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) clamp_r[k] <= clamp_r[k-1];
    end
  end

  assign quo = clamp_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_r[QB]};

endmodule

// ----- design/closest_points_two_lines_3d_unit.sv -----
// Top level: closest points between two 3D lines, fully pipelined.
//
// Input channel (in_*): two lines, each as a start and an end point, signed
// fixed point. A word is taken at a clock edge with in_valid high and
// in_stall low. Output channel (out_*): closest point on each line plus the
// parallel and in-segments flags, taken with out_valid high and
// out_stall low. cfg_wr_en with cfg_wr_data writes the parallel limit.
// Throughput: one word per cycle while in_stall is low. The depth from
// accept to out_valid is set mostly by the restoring divider, one
// quotient bit per stage (COORD_WIDTH+33 stages), plus the chunked wide
// multipliers.
// All stages advance together while the skid register is empty. With the
// receiver stalled, the pipeline keeps moving until a second finished word
// lands in the skid register behind the held output word; in_stall then
// rises and falls again the cycle after the held word is taken.
// Reset (synchronous, rst_n low) clears all valid bits and sets the limit
// to one; no clearing pass is needed.
module closest_points_two_lines_3d_unit #(
  parameter int COORD_WIDTH = clpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [clpt_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_line1_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_line1_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_line1_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_line1_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_line1_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_line1_end_z,
  input  logic signed [COORD_WIDTH-1:0] in_line2_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_line2_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_line2_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_line2_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_line2_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_line2_end_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_near1_x,
  output logic signed [COORD_WIDTH-1:0] out_near1_y,
  output logic signed [COORD_WIDTH-1:0] out_near1_z,
  output logic signed [COORD_WIDTH-1:0] out_near2_x,
  output logic signed [COORD_WIDTH-1:0] out_near2_y,
  output logic signed [COORD_WIDTH-1:0] out_near2_z,
  output logic                          out_is_parallel,
  output logic                          out_within_segments
);
  import clpt_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DFW  = W + 1;
  localparam int M1W  = 2 * DFW;
  localparam int PW   = 2 * W + 4;
  localparam int M2W  = 2 * PW;
  localparam int DW   = 4 * W + 4;
  localparam int NW   = 4 * W + 6;
  localparam int NMW  = NW - 1;
  localparam int QB   = W + SFRAC + 1;
  localparam int QSW  = QB + 2;
  localparam int M3W  = QSW + DFW;
  localparam int SUMW = M3W + 1;
  localparam int SHW  = SUMW - SFRAC;
  localparam int C1   = (DFW + MUL_CW - 1) / MUL_CW;
  localparam int C2   = (PW + MUL_CW - 1) / MUL_CW;
  localparam int C3   = (QSW + MUL_CW - 1) / MUL_CW;
  localparam int LM1  = C1 * C1 + 2;
  localparam int LM2  = C2 * C2 + 2;
  localparam int LD   = QB + 1;
  localparam int LM3  = C3 * C1 + 2;

  typedef struct packed {
    logic                 vld;
    logic [2:0][W-1:0]    p1;
    logic [2:0][W-1:0]    p2;
    logic [2:0][DFW-1:0]  d1;
    logic [2:0][DFW-1:0]  d2;
    logic                 par;
    logic                 in_seg;
    logic                 sneg;
    logic                 tneg;
  } side_t;

  typedef struct packed {
    logic [2:0][W-1:0] near1;
    logic [2:0][W-1:0] near2;
    logic              par;
    logic              in_seg;
  } res_t;

  logic                en;
  logic [LIMIT_W-1:0]  limit_r;
  logic [2:0][W-1:0]   lp1, lq1, lp2, lq2;

  side_t               s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;
  side_t               s4_nxt;
  side_t               sa_r [LM1];
  side_t               sb_r [LM2];
  side_t               sc_r [LD];
  side_t               sd_r [LM3];

  logic [DFW-1:0]      r_r   [3];
  logic [M1W-1:0]      pa [3], pb [3], pc [3], pe [3], pf [3];
  logic [PW-1:0]       a_r, b_r, c_r, e_r, f_r;
  logic [M2W-1:0]      ae, bb, bf, ce, af, bc;
  logic [DW-1:0]       d_r, d4_r;
  logic [NW-1:0]       ns_r, nt_r;
  logic [NMW-1:0]      nsm_r, ntm_r;
  logic [QB:0]         qs_mag, qt_mag;
  logic [QSW-1:0]      qs_r, qt_r;
  logic [M3W-1:0]      ps [3], pt [3];
  logic [SHW-1:0]      sh1_r [3], sh2_r [3];

  res_t                pipe_res, out_r, skid_r;
  logic                out_vld_r, skid_vld_r, out_take;

  // Saturate a floored coordinate to the output range
  function automatic logic [W-1:0] sat_c(input logic [SHW-1:0] v);
    logic fits;
    fits = (&v[SHW-1:W-1]) | (~|v[SHW-1:W-1]);
    if (fits) begin
      return v[W-1:0];
    end else if (v[SHW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // Advance the whole pipeline unless the skid register is occupied
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Gather input points
  always_comb begin
    lp1 = {in_line1_start_z, in_line1_start_y, in_line1_start_x};
    lq1 = {in_line1_end_z,   in_line1_end_y,   in_line1_end_x};
    lp2 = {in_line2_start_z, in_line2_start_y, in_line2_start_x};
    lq2 = {in_line2_end_z,   in_line2_end_y,   in_line2_end_x};
  end

  // Stage 1: direction and offset vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (en) begin
      s1_r.vld    <= in_valid;
      s1_r.p1     <= lp1;
      s1_r.p2     <= lp2;
      s1_r.par    <= 1'b0;
      s1_r.in_seg <= 1'b0;
      s1_r.sneg   <= 1'b0;
      s1_r.tneg   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        s1_r.d1[k] <= DFW'($signed(lq1[k])) - DFW'($signed(lp1[k]));
        s1_r.d2[k] <= DFW'($signed(lq2[k])) - DFW'($signed(lp2[k]));
        r_r[k]     <= DFW'($signed(lp1[k])) - DFW'($signed(lp2[k]));
      end
    end
  end

  // Component products of the dot products
  for (genvar k = 0; k < 3; k++) begin : g_dot
    clpt_mul #(.AW(DFW), .BW(DFW)) u_ma (
      .clk(clk), .en(en), .a(s1_r.d1[k]), .b(s1_r.d1[k]), .p(pa[k]));
    clpt_mul #(.AW(DFW), .BW(DFW)) u_mb (
      .clk(clk), .en(en), .a(s1_r.d1[k]), .b(s1_r.d2[k]), .p(pb[k]));
    clpt_mul #(.AW(DFW), .BW(DFW)) u_mc (
      .clk(clk), .en(en), .a(s1_r.d1[k]), .b(r_r[k]), .p(pc[k]));
    clpt_mul #(.AW(DFW), .BW(DFW)) u_me (
      .clk(clk), .en(en), .a(s1_r.d2[k]), .b(s1_r.d2[k]), .p(pe[k]));
    clpt_mul #(.AW(DFW), .BW(DFW)) u_mf (
      .clk(clk), .en(en), .a(s1_r.d2[k]), .b(r_r[k]), .p(pf[k]));
  end

  // Hold side data alongside the first multipliers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LM1; i++) sa_r[i].vld <= 1'b0;
    end else if (en) begin
      sa_r[0] <= s1_r;
      for (int i = 1; i < LM1; i++) sa_r[i] <= sa_r[i-1];
    end
  end

  // Stage 2: dot product sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s2_r <= sa_r[LM1-1];
      a_r  <= PW'($signed(pa[0])) + PW'($signed(pa[1])) + PW'($signed(pa[2]));
      b_r  <= PW'($signed(pb[0])) + PW'($signed(pb[1])) + PW'($signed(pb[2]));
      c_r  <= PW'($signed(pc[0])) + PW'($signed(pc[1])) + PW'($signed(pc[2]));
      e_r  <= PW'($signed(pe[0])) + PW'($signed(pe[1])) + PW'($signed(pe[2]));
      f_r  <= PW'($signed(pf[0])) + PW'($signed(pf[1])) + PW'($signed(pf[2]));
    end
  end

  // Wide products for the determinant and numerators
  clpt_mul #(.AW(PW), .BW(PW)) u_ae (.clk(clk), .en(en), .a(a_r), .b(e_r), .p(ae));
  clpt_mul #(.AW(PW), .BW(PW)) u_bb (.clk(clk), .en(en), .a(b_r), .b(b_r), .p(bb));
  clpt_mul #(.AW(PW), .BW(PW)) u_bf (.clk(clk), .en(en), .a(b_r), .b(f_r), .p(bf));
  clpt_mul #(.AW(PW), .BW(PW)) u_ce (.clk(clk), .en(en), .a(c_r), .b(e_r), .p(ce));
  clpt_mul #(.AW(PW), .BW(PW)) u_af (.clk(clk), .en(en), .a(a_r), .b(f_r), .p(af));
  clpt_mul #(.AW(PW), .BW(PW)) u_bc (.clk(clk), .en(en), .a(b_r), .b(c_r), .p(bc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LM2; i++) sb_r[i].vld <= 1'b0;
    end else if (en) begin
      sb_r[0] <= s2_r;
      for (int i = 1; i < LM2; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // Stage 3: determinant and numerators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s3_r <= sb_r[LM2-1];
      d_r  <= DW'(ae - bb);
      ns_r <= NW'(bf - ce);
      nt_r <= NW'(af - bc);
    end
  end

  // Parallel test, segment test and signs for stage 4
  always_comb begin
    s4_nxt        = s3_r;
    s4_nxt.par    = (d_r == '0) || (d_r < DW'(limit_r));
    s4_nxt.in_seg = !ns_r[NW-1] && (ns_r <= NW'(d_r)) &&
                    !nt_r[NW-1] && (nt_r <= NW'(d_r));
    s4_nxt.sneg   = ns_r[NW-1];
    s4_nxt.tneg   = nt_r[NW-1];
  end

  // Stage 4: flags, magnitudes and signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld <= 1'b0;
    end else if (en) begin
      s4_r  <= s4_nxt;
      nsm_r <= ns_r[NW-1] ? NMW'(NW'(0) - ns_r) : NMW'(ns_r);
      ntm_r <= nt_r[NW-1] ? NMW'(NW'(0) - nt_r) : NMW'(nt_r);
      d4_r  <= d_r;
    end
  end

  // Fractions s and t
  clpt_div #(.NUMW(NMW), .DENW(DW), .QB(QB)) u_div_s (
    .clk(clk), .en(en), .num(nsm_r), .den(d4_r), .quo(qs_mag));
  clpt_div #(.NUMW(NMW), .DENW(DW), .QB(QB)) u_div_t (
    .clk(clk), .en(en), .num(ntm_r), .den(d4_r), .quo(qt_mag));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LD; i++) sc_r[i].vld <= 1'b0;
    end else if (en) begin
      sc_r[0] <= s4_r;
      for (int i = 1; i < LD; i++) sc_r[i] <= sc_r[i-1];
    end
  end

  // Stage 5: apply signs to the fractions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.vld <= 1'b0;
    end else if (en) begin
      s5_r <= sc_r[LD-1];
      qs_r <= sc_r[LD-1].sneg ? (QSW'(0) - QSW'(qs_mag)) : QSW'(qs_mag);
      qt_r <= sc_r[LD-1].tneg ? (QSW'(0) - QSW'(qt_mag)) : QSW'(qt_mag);
    end
  end

  // Scale the directions
  for (genvar k = 0; k < 3; k++) begin : g_pt
    clpt_mul #(.AW(QSW), .BW(DFW)) u_ps (
      .clk(clk), .en(en), .a(qs_r), .b(s5_r.d1[k]), .p(ps[k]));
    clpt_mul #(.AW(QSW), .BW(DFW)) u_pt (
      .clk(clk), .en(en), .a(qt_r), .b(s5_r.d2[k]), .p(pt[k]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LM3; i++) sd_r[i].vld <= 1'b0;
    end else if (en) begin
      sd_r[0] <= s5_r;
      for (int i = 1; i < LM3; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // Stage 6: add to the start points and floor away the fraction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.vld <= 1'b0;
    end else if (en) begin
      s6_r <= sd_r[LM3-1];
      for (int k = 0; k < 3; k++) begin
        sh1_r[k] <= SHW'(((SUMW'($signed(sd_r[LM3-1].p1[k])) << SFRAC) +
                          SUMW'($signed(ps[k]))) >> SFRAC);
        sh2_r[k] <= SHW'(((SUMW'($signed(sd_r[LM3-1].p2[k])) << SFRAC) +
                          SUMW'($signed(pt[k]))) >> SFRAC);
      end
    end
  end

  // Saturate and select the parallel fallback
  always_comb begin
    pipe_res.par    = s6_r.par;
    pipe_res.in_seg = s6_r.in_seg && !s6_r.par;
    for (int k = 0; k < 3; k++) begin
      pipe_res.near1[k] = s6_r.par ? s6_r.p1[k] : sat_c(sh1_r[k]);
      pipe_res.near2[k] = s6_r.par ? s6_r.p2[k] : sat_c(sh2_r[k]);
    end
  end

  // Output register and skid register
  assign out_take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (s6_r.vld) begin
      if (!out_vld_r || out_take) begin
        out_r     <= pipe_res;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= pipe_res;
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_near1_x         = out_r.near1[0];
  assign out_near1_y         = out_r.near1[1];
  assign out_near1_z         = out_r.near1[2];
  assign out_near2_x         = out_r.near2[0];
  assign out_near2_y         = out_r.near2[1];
  assign out_near2_z         = out_r.near2[2];
  assign out_is_parallel     = out_r.par;
  assign out_within_segments = out_r.in_seg;

  // Skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full with no output word");

  // Skid fills only when the output was blocked
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid register filled without a stall");

  // A word leaving the pipeline into a blocked output goes to the skid
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s6_r.vld && out_vld_r && out_stall) |=> skid_vld_r)
    else $error("word dropped at the output");

  // Parallel results never claim to lie in the segments
  a_par_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.par) |-> !out_r.in_seg)
    else $error("parallel word flagged within segments");

endmodule
